/* rtl/wbc_pkg.sv */
// Shared constants, codes, types and the item record for the word break checker.
package wbc_pkg;

  localparam int MAX_WORDS    = 1024;
  localparam int MAX_WORD_LEN = 8;
  localparam int SYM_W        = 3;
  localparam int HIST_W       = SYM_W * MAX_WORD_LEN;
  localparam int WIN_W        = MAX_WORD_LEN + 1;
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int COUNT_W      = $clog2(MAX_WORDS + 1);
  localparam int ADDR_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ENTRY_W      = LEN_W + HIST_W;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_SYMBOL = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_SYMBOL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [HIST_W-1:0] syms;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  color;
    logic              last;
  } cmd_t;

endpackage

/* rtl/wbc_front.sv */
// Front end: accepts items, classifies them and queues commands for the back end.
module wbc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 func,
  input  logic [wbc_pkg::HIST_W-1:0] word_colors,
  input  logic [wbc_pkg::LEN_W-1:0]  word_length,
  input  logic [wbc_pkg::SYM_W-1:0]  color,
  input  logic                       last,
  output logic                       cmd_valid,
  output wbc_pkg::cmd_t              cmd,
  input  logic                       cmd_take
);
  import wbc_pkg::*;

  cmd_t               queue [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  cmd_t               cls;
  logic               keep;
  logic               enq;
  logic [SYM_W-1:0]   src;

  // A word is stored with its last symbol in the lowest bits, matching the history order.
  always_comb begin
    cls.op    = OP_SYMBOL;
    cls.syms  = '0;
    cls.len   = word_length;
    cls.color = color;
    cls.last  = last;
    keep      = 1'b0;
    src       = '0;
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      src = SYM_W'(word_length - LEN_W'(1) - LEN_W'(j));
      if (LEN_W'(j) < word_length) begin
        cls.syms[SYM_W*j +: SYM_W] = word_colors[SYM_W*src +: SYM_W];
      end
    end
    case (func)
      FUNC_CLEAR: begin
        cls.op = OP_CLEAR;
        keep   = 1'b1;
      end
      FUNC_ADD: begin
        cls.op = OP_ADD;
        keep   = (word_length != '0) && (word_length <= LEN_W'(MAX_WORD_LEN));
      end
      FUNC_SYMBOL: begin
        cls.op = OP_SYMBOL;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == FIFO_CW'(FIFO_DEPTH));
  assign enq       = push && !full && keep;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (enq && !cmd_take) begin
        count <= count + FIFO_CW'(1);
      end else if (!enq && cmd_take) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule

/* rtl/wbc_back.sv */
// Back end: dictionary store, reachability scan over stored words and the result register.
module wbc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  wbc_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output logic          possible,
  output logic          dictionary_overflow
);
  import wbc_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_WORDS];
  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] word_count;
  logic [HIST_W-1:0]  history;
  logic [HIST_W-1:0]  hist_new;
  logic [WIN_W-1:0]   window;
  logic               overflow;
  logic               cur_last;
  logic [COUNT_W-1:0] scan_cnt;
  logic [ENTRY_W-1:0] rdata;
  logic               rd_valid;
  logic               found;
  logic               hit_now;
  logic               issue;
  logic               scan_done;
  logic               res_wr;
  logic               res_valid;
  logic               finish_go;

  function automatic logic word_hit(input logic [ENTRY_W-1:0] entry,
                                    input logic [HIST_W-1:0] hist,
                                    input logic [WIN_W-1:0] win);
    logic [LEN_W-1:0] len;
    logic             ok;
    len = entry[ENTRY_W-1 -: LEN_W];
    ok  = win[len - LEN_W'(1)];
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      if ((LEN_W'(j) < len) && (entry[SYM_W*j +: SYM_W] != hist[SYM_W*j +: SYM_W])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign hit_now   = rd_valid && word_hit(rdata, hist_new, window);
  assign scan_done = found || hit_now || ((scan_cnt == word_count) && !rd_valid);
  assign finish_go = !cur_last || !res_valid || pop;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.op == OP_SYMBOL) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_take = 1'b0;
    issue    = 1'b0;
    res_wr   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_take = cmd_valid;
      end
      ST_SCAN: begin
        issue = !found && (scan_cnt < word_count);
      end
      ST_FINISH: begin
        res_wr = cur_last && finish_go;
      end
      default: begin
        cmd_take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.op == OP_ADD && word_count != COUNT_W'(MAX_WORDS)) begin
      mem[word_count[ADDR_W-1:0]] <= {cmd.len, cmd.syms};
    end
    if (issue) begin
      rdata <= mem[scan_cnt[ADDR_W-1:0]];
    end
    if (cmd_take) begin
      hist_new <= {history[HIST_W-SYM_W-1:0], cmd.color};
      cur_last <= cmd.last;
    end
    if (res_wr) begin
      possible            <= found;
      dictionary_overflow <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_count <= '0;
      history    <= '0;
      window     <= WIN_W'(1);
      overflow   <= 1'b0;
      scan_cnt   <= '0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (issue) begin
        scan_cnt <= scan_cnt + COUNT_W'(1);
      end
      if (hit_now) begin
        found <= 1'b1;
      end
      if (cmd_take) begin
        case (cmd.op)
          OP_CLEAR: begin
            word_count <= '0;
            overflow   <= 1'b0;
            history    <= '0;
            window     <= WIN_W'(1);
          end
          OP_ADD: begin
            if (word_count == COUNT_W'(MAX_WORDS)) begin
              overflow <= 1'b1;
            end else begin
              word_count <= word_count + COUNT_W'(1);
            end
          end
          OP_SYMBOL: begin
            scan_cnt <= '0;
            found    <= 1'b0;
          end
          default: begin
            found <= 1'b0;
          end
        endcase
      end
      if (state == ST_FINISH && finish_go) begin
        if (cur_last) begin
          history <= '0;
          window  <= WIN_W'(1);
        end else begin
          history <= hist_new;
          window  <= {window[WIN_W-2:0], found};
        end
      end
      if (res_wr) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign empty = !res_valid;

endmodule

/* rtl/word_break_checker.sv */
// Top level of the word break checker: front end, command queue and back end.
//
// Usage: items enter through a queue-style port (push, full) and carry func, word_colors,
// word_length, color and last. Clear and add-word items build the dictionary; pattern
// symbols stream in one per item. The symbol marked last yields one result (possible,
// dictionary_overflow), read through a queue-style port (empty, pop).
// The back end takes a clear or add item while idle. A pattern symbol scans the
// stored words one per cycle from a single-port word memory, so it holds the back end
// until a matching word is found or every stored word has been read. The result of a
// last symbol is written to the output register as the back end leaves its finish state.
// Up to four classified items wait between the front and the back end, so the input
// keeps taking items while a scan runs; full rises only when that queue is full.
// Reset empties the dictionary, clears the overflow flag and starts a new pattern. The
// word memory needs no clearing pass; entries beyond the word count are never read.
// When the receiver stalls, one result waits in the output register; a further last
// symbol then holds in the back end until the waiting result is popped.
module word_break_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 func,
  input  logic [wbc_pkg::HIST_W-1:0] word_colors,
  input  logic [wbc_pkg::LEN_W-1:0]  word_length,
  input  logic [wbc_pkg::SYM_W-1:0]  color,
  input  logic                       last,
  output logic                       empty,
  input  logic                       pop,
  output logic                       possible,
  output logic                       dictionary_overflow
);
  import wbc_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  wbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .word_colors (word_colors),
    .word_length (word_length),
    .color       (color),
    .last        (last),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  wbc_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_take            (cmd_take),
    .empty               (empty),
    .pop                 (pop),
    .possible            (possible),
    .dictionary_overflow (dictionary_overflow)
  );

  a_reset_clears : assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_take_valid : assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("back end took an item from an empty queue");

  a_full_has_head : assert property (@(posedge clk) disable iff (rst) full |-> cmd_valid)
    else $error("input reports full while the command queue is empty");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the word break checker: dictionary loads, patterns and overflow.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wbc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic possible;
    logic overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] func = FUNC_CLEAR;
  logic [HIST_W-1:0] word_colors = '0;
  logic [LEN_W-1:0] word_length = '0;
  logic [SYM_W-1:0] color = '0;
  logic last = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic possible;
  logic dictionary_overflow;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int errors = 0;
  int unsigned cycle_count = 0;

  logic [HIST_W-1:0] dict_syms [MAX_WORDS];
  logic [LEN_W-1:0] dict_len [MAX_WORDS];
  int dict_count = 0;
  logic [HIST_W-1:0] pat_hist = '0;
  logic [WIN_W-1:0] reach_win = WIN_W'(1);
  logic overflow_seen = 1'b0;
  verdict_t expected_verdicts [$];

  word_break_checker dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .func(func),
    .word_colors(word_colors),
    .word_length(word_length),
    .color(color),
    .last(last),
    .empty(empty),
    .pop(pop),
    .possible(possible),
    .dictionary_overflow(dictionary_overflow)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic word_ends_here(input logic [HIST_W-1:0] syms,
                                          input logic [LEN_W-1:0] len,
                                          input logic [HIST_W-1:0] hist);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < len; k++) begin
      if (syms[SYM_W*k +: SYM_W] != hist[SYM_W*(len-1-k) +: SYM_W]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void predict_item(input logic [1:0] f, input logic [HIST_W-1:0] wc,
                                       input logic [LEN_W-1:0] wl, input logic [SYM_W-1:0] col,
                                       input logic lst);
    logic [HIST_W-1:0] hist;
    logic [HIST_W-1:0] mask;
    logic hit;
    verdict_t v;
    case (f)
      FUNC_CLEAR: begin
        dict_count = 0;
        overflow_seen = 1'b0;
        pat_hist = '0;
        reach_win = WIN_W'(1);
      end
      FUNC_ADD: begin
        if (wl != 0 && wl <= MAX_WORD_LEN) begin
          if (dict_count >= MAX_WORDS) begin
            overflow_seen = 1'b1;
          end else begin
            mask = '0;
            for (int k = 0; k < wl; k++) mask[SYM_W*k +: SYM_W] = '1;
            dict_syms[dict_count] = wc & mask;
            dict_len[dict_count] = wl;
            dict_count++;
          end
        end
      end
      FUNC_SYMBOL: begin
        hist = {pat_hist[HIST_W-SYM_W-1:0], col};
        hit = 1'b0;
        for (int i = 0; i < dict_count; i++) begin
          if (!hit && reach_win[dict_len[i]-1] && word_ends_here(dict_syms[i], dict_len[i], hist))
            hit = 1'b1;
        end
        pat_hist = hist;
        reach_win = {reach_win[WIN_W-2:0], hit};
        if (lst) begin
          v.possible = hit;
          v.overflow = overflow_seen;
          expected_verdicts.push_back(v);
          pat_hist = '0;
          reach_win = WIN_W'(1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: possible %0b, dictionary_overflow %0b",
                 possible, dictionary_overflow);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (possible !== want.possible) begin
            $error("possible: expected %0b, actual %0b", want.possible, possible);
            errors++;
          end
          if (dictionary_overflow !== want.overflow) begin
            $error("dictionary_overflow: expected %0b, actual %0b",
                   want.overflow, dictionary_overflow);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [HIST_W-1:0] wc,
                           input logic [LEN_W-1:0] wl, input logic [SYM_W-1:0] col,
                           input logic lst);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= f;
    word_colors <= wc;
    word_length <= wl;
    color <= col;
    last <= lst;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_item(f, wc, wl, col, lst);
  endtask

  task automatic add_word(input logic [HIST_W-1:0] syms, input int len);
    send_item(FUNC_ADD, syms, LEN_W'(len), SYM_W'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] col, input logic lst);
    send_item(FUNC_SYMBOL, HIST_W'($urandom()), LEN_W'($urandom_range(15)), col, lst);
  endtask

  task automatic clear_dictionary();
    send_item(FUNC_CLEAR, HIST_W'($urandom()), LEN_W'($urandom_range(15)),
              SYM_W'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic test_empty_dictionary();
    send_symbol(3'd4, 1'b1);
  endtask

  task automatic test_directed_words();
    clear_dictionary();
    add_word(24'h000000, 1);
    add_word(24'hFFFFD1, 2);
    add_word(24'hFFFFFF, MAX_WORD_LEN);
    add_word(24'hFFFFE3, 2);
    add_word(24'h000001, 0);
    add_word(24'h000002, MAX_WORD_LEN + 1);
    add_word(24'h000003, 15);
    send_item(FUNC_NONE, 24'hFFFFFF, 4'hF, 3'd7, 1'b1);
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd2, 1'b1);
    send_symbol(3'd1, 1'b1);
    for (int k = 0; k < MAX_WORD_LEN; k++) send_symbol(3'd7, k == MAX_WORD_LEN - 1);
    send_symbol(3'd3, 1'b0);
    send_symbol(3'd4, 1'b0);
    send_symbol(3'd0, 1'b1);
  endtask

  task automatic test_store_overflow();
    clear_dictionary();
    add_word(24'h000000, 1);
    for (int k = 1; k < MAX_WORDS + 2; k++)
      add_word(HIST_W'($urandom()), $urandom_range(1, MAX_WORD_LEN));
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd0, 1'b1);
    send_symbol(SYM_W'($urandom_range(7)), 1'b1);
    add_word(HIST_W'($urandom()), 0);
    clear_dictionary();
    send_symbol(3'd0, 1'b1);
  endtask

  task automatic test_random_sequences(input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int pick;
    int n_words;
    int len;
    int idx;
    logic [HIST_W-1:0] syms;
    logic [SYM_W-1:0] sym_q [$];
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (dict_count == 0 || dict_count > 24 || pick < 8) begin
        if (dict_count > 24 || $urandom_range(1)) begin
          clear_dictionary();
          sent++;
        end
        n_words = $urandom_range(2, 6);
        for (int k = 0; k < n_words; k++) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_WORD_LEN) : $urandom_range(1, 3);
          syms = HIST_W'($urandom());
          for (int j = 0; j < len; j++)
            syms[SYM_W*j +: SYM_W] = ($urandom_range(7) == 0) ? SYM_W'($urandom_range(7))
                                                               : SYM_W'($urandom_range(2));
          add_word(syms, len);
          sent++;
        end
      end else if (pick < 80) begin
        sym_q.delete();
        n_words = $urandom_range(1, 4);
        for (int k = 0; k < n_words; k++) begin
          idx = $urandom_range(dict_count - 1);
          for (int j = 0; j < dict_len[idx]; j++) sym_q.push_back(dict_syms[idx][SYM_W*j +: SYM_W]);
        end
        if ($urandom_range(4) == 0)
          sym_q[$urandom_range(sym_q.size() - 1)] = SYM_W'($urandom_range(7));
        for (int p = 0; p < sym_q.size(); p++) begin
          send_symbol(sym_q[p], p == sym_q.size() - 1);
          sent++;
        end
      end else if (pick < 90) begin
        len = $urandom_range(1, 6);
        for (int p = 0; p < len; p++) begin
          send_symbol(SYM_W'($urandom_range(7)), p == len - 1);
          sent++;
        end
      end else begin
        case ($urandom_range(2))
          0: begin
            send_item(FUNC_NONE, HIST_W'($urandom()), LEN_W'($urandom_range(15)),
                      SYM_W'($urandom_range(7)), 1'($urandom_range(1)));
            sent++;
          end
          1: begin
            add_word(HIST_W'($urandom()),
                     $urandom_range(1) ? 0 : $urandom_range(MAX_WORD_LEN + 1, 15));
            sent++;
          end
          default: begin
            send_symbol(SYM_W'($urandom_range(7)), 1'b0);
            clear_dictionary();
            sent += 2;
          end
        endcase
      end
    end
  endtask

  task automatic drain_results();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    push <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (MAX_WORDS + 16) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_dictionary();
    test_directed_words();
    test_store_overflow();
    test_random_sequences(145, 0, 0);
    test_random_sequences(145, 51, 0);
    test_random_sequences(145, 0, 51);
    test_random_sequences(145, 14, 14);
    drain_results();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
